>>> rtl/core/spq_pkg.sv
// Shared types and codes for the stable priority ready queue.
package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam int TASK_W = 8;
  localparam int PRIO_IN_W = 8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_LAST,
    S_RM_RD,
    S_RM_CMP,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    status_t           status;
  } result_t;

endpackage

>>> rtl/core/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/spq_seq.sv
// Sequencer that inserts and removes queue entries one slot move at a time.
module spq_seq #(
  parameter int DEPTH  = 16,
  parameter int PRIO_W = 8,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int WORD_W = spq_pkg::TASK_W + PRIO_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [spq_pkg::TASK_W-1:0]     task_id,
  input  logic [spq_pkg::PRIO_IN_W-1:0]  task_priority,
  output logic                           res_valid,
  input  logic                           res_ready,
  output spq_pkg::result_t               res,
  output logic [CW-1:0]                  res_occ,
  output logic                           we,
  output logic [AW-1:0]                  waddr,
  output logic [WORD_W-1:0]              wdata,
  output logic                           re,
  output logic [AW-1:0]                  raddr,
  input  logic [WORD_W-1:0]              rdata
);

  spq_pkg::seq_state_t state, state_next;

  logic [CW-1:0]              cnt;
  logic [AW-1:0]              ptr;
  logic                       op_kind;
  logic [spq_pkg::TASK_W-1:0] new_task;
  logic [PRIO_W-1:0]          new_prio;
  spq_pkg::result_t           result;

  logic                       accept;
  logic                       full;
  logic                       empty;
  logic [PRIO_W-1:0]          prio_in;
  logic [spq_pkg::PRIO_IN_W+15:0] prio_wide;
  logic [spq_pkg::TASK_W-1:0] rd_task;
  logic [PRIO_W-1:0]          rd_prio;
  logic                       stop_here;
  logic                       rm_last;

  assign accept    = in_valid && in_ready;
  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);
  // Priority bits above PRIO_W are dropped; narrower inputs are zero-extended.
  assign prio_wide = {16'b0, task_priority};
  assign prio_in   = prio_wide[PRIO_W-1:0];
  assign rd_task   = rdata[WORD_W-1:PRIO_W];
  assign rd_prio   = rdata[PRIO_W-1:0];
  // The new task goes right behind the first entry, seen from the tail, that is not lower.
  assign stop_here = (rd_prio >= new_prio);
  assign rm_last   = ((CW'(ptr) + CW'(1)) == cnt);

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (kind == spq_pkg::KIND_INSERT) begin
            if (full) begin
              state_next = spq_pkg::S_DONE;
            end else if (empty) begin
              state_next = spq_pkg::S_INS_LAST;
            end else begin
              state_next = spq_pkg::S_INS_RD;
            end
          end else begin
            state_next = empty ? spq_pkg::S_DONE : spq_pkg::S_RM_RD;
          end
        end
      end
      spq_pkg::S_INS_RD: state_next = spq_pkg::S_INS_CMP;
      spq_pkg::S_INS_CMP: begin
        if (stop_here) begin
          state_next = spq_pkg::S_DONE;
        end else if (ptr == '0) begin
          state_next = spq_pkg::S_INS_LAST;
        end else begin
          state_next = spq_pkg::S_INS_RD;
        end
      end
      spq_pkg::S_INS_LAST: state_next = spq_pkg::S_DONE;
      spq_pkg::S_RM_RD:    state_next = spq_pkg::S_RM_CMP;
      spq_pkg::S_RM_CMP:   state_next = rm_last ? spq_pkg::S_DONE : spq_pkg::S_RM_RD;
      spq_pkg::S_DONE:     state_next = res_ready ? spq_pkg::S_IDLE : spq_pkg::S_DONE;
      default:             state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    we        = 1'b0;
    waddr     = ptr + AW'(1);
    wdata     = {new_task, new_prio};
    re        = 1'b0;
    raddr     = ptr;
    unique case (state)
      spq_pkg::S_IDLE: in_ready = 1'b1;
      spq_pkg::S_INS_RD: re = 1'b1;
      spq_pkg::S_INS_CMP: begin
        we    = 1'b1;
        wdata = stop_here ? {new_task, new_prio} : rdata;
      end
      spq_pkg::S_INS_LAST: begin
        we    = 1'b1;
        waddr = '0;
      end
      spq_pkg::S_RM_RD: re = 1'b1;
      spq_pkg::S_RM_CMP: begin
        we    = (ptr != '0);
        waddr = ptr - AW'(1);
        wdata = rdata;
      end
      spq_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == spq_pkg::S_INS_CMP && stop_here) || state == spq_pkg::S_INS_LAST) begin
        cnt <= cnt + CW'(1);
      end else if (state == spq_pkg::S_RM_CMP && rm_last) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind        <= kind;
      new_task       <= task_id;
      new_prio       <= prio_in;
      result.task_id <= '0;
      ptr            <= (kind == spq_pkg::KIND_INSERT) ? AW'(cnt - CW'(1)) : '0;
      if (kind == spq_pkg::KIND_INSERT && full) begin
        result.status <= spq_pkg::ST_FULL;
      end else if (kind == spq_pkg::KIND_REMOVE && empty) begin
        result.status <= spq_pkg::ST_EMPTY;
      end else begin
        result.status <= spq_pkg::ST_OK;
      end
    end else if (state == spq_pkg::S_INS_CMP && !stop_here) begin
      ptr <= ptr - AW'(1);
    end else if (state == spq_pkg::S_RM_CMP) begin
      if (ptr == '0) begin
        result.task_id <= rd_task;
      end
      ptr <= ptr + AW'(1);
    end
  end

  assign res     = result;
  assign res_occ = cnt;

  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("Queue count exceeds depth.");
  assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_INS_CMP || state == spq_pkg::S_RM_CMP) |-> (CW'(ptr) < cnt))
    else $error("Scan pointer beyond stored entries.");
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && result.status == spq_pkg::ST_FULL) |-> (cnt == CW'(DEPTH)))
    else $error("Full status with room left.");
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && result.status == spq_pkg::ST_EMPTY) |-> (cnt == '0 && result.task_id == '0))
    else $error("Empty status with entries stored.");
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && op_kind == spq_pkg::KIND_INSERT) |-> (result.task_id == '0))
    else $error("Insert result carries a task.");

endmodule

>>> rtl/core/stable_priority_ready_queue_core.sv
// Insert scans from the tail, shifting each lower-priority entry back one slot.
// Remove returns the head entry; every entry behind it moves up one slot.
// A full or empty refusal skips the scan and goes straight to the result.
// One item at a time: input is ready again in the cycle after the result reaches the
// output register; the slot RAM read port and the priority compare set the pace.
// Reset empties the queue through the fill count; slot contents are not cleared.
module stable_priority_ready_queue_core #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1),
  localparam int AW    = $clog2(QUEUE_DEPTH),
  localparam int WORD_W = spq_pkg::TASK_W + PRIORITY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [spq_pkg::TASK_W-1:0]    task_id,
  input  logic [spq_pkg::PRIO_IN_W-1:0] task_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spq_pkg::TASK_W-1:0]    out_task,
  output logic [1:0]                    status,
  output logic [OCC_W-1:0]              occupancy
);

  logic             res_valid;
  logic             res_ready;
  spq_pkg::result_t res;
  logic [OCC_W-1:0] res_occ;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [WORD_W-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [WORD_W-1:0] rdata;
  logic             out_valid_next;

  spq_seq #(
    .DEPTH  (QUEUE_DEPTH),
    .PRIO_W (PRIORITY_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .task_id       (task_id),
    .task_priority (task_priority),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .res_occ       (res_occ),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata),
    .re            (re),
    .raddr         (raddr),
    .rdata         (rdata)
  );

  spq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The output register frees the sequencer as soon as a result is parked here.
  assign res_ready = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (res_valid && res_ready) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_task  <= res.task_id;
      status    <= res.status;
      occupancy <= res_occ;
    end
  end

endmodule
